// ----- rtl/lpic_pkg.sv -----
// lift pid and intake control: shared types, register codes and constants
// used by every module of the block; depends on nothing else
`default_nettype none

package lpic_pkg;

  // field widths
  localparam int ANGLE_W  = 20;
  localparam int ERR_W    = 21;
  localparam int DERIV_W  = 22;
  localparam int INTEG_W  = 32;
  localparam int GAIN_W   = 24;
  localparam int DRIVE_W  = 15;
  localparam int MAG_W    = 16;
  localparam int P_PROD_W = GAIN_W + ERR_W;
  localparam int I_PROD_W = GAIN_W + INTEG_W;
  localparam int D_PROD_W = GAIN_W + DERIV_W;
  localparam int SUM_W    = I_PROD_W + 2;

  // gain fraction bits and drive saturation
  localparam int GAIN_FRAC_BITS = 8;
  localparam int DRIVE_LIMIT_MV = 12000;

  // stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_P_GAIN        = 3'd0,
    REG_I_GAIN        = 3'd1,
    REG_D_GAIN        = 3'd2,
    REG_DEAD_BAND     = 3'd3,
    REG_INTEGRAL_ZONE = 3'd4,
    REG_TOP_TARGET    = 3'd5,
    REG_BOTTOM_TARGET = 3'd6,
    REG_COAST_MARGIN  = 3'd7
  } reg_idx_t;

  // lift action codes
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_COAST = 2'd1,
    ACT_DRIVE = 2'd2
  } action_t;

  // motor command codes
  typedef enum logic [1:0] {
    CMD_KEEP  = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_REV   = 2'd2,
    CMD_BRAKE = 2'd3
  } cmd_t;

  // configuration register set
  typedef struct packed {
    logic signed [GAIN_W-1:0]  p_gain;
    logic signed [GAIN_W-1:0]  i_gain;
    logic signed [GAIN_W-1:0]  d_gain;
    logic [MAG_W-1:0]          dead_band;
    logic [MAG_W-1:0]          integral_zone;
    logic signed [ANGLE_W-1:0] top_target;
    logic signed [ANGLE_W-1:0] bottom_target;
    logic [MAG_W-1:0]          coast_margin;
  } cfg_t;

  // per-tick control flags carried down the pipeline
  typedef struct packed {
    logic step;
    logic coast;
    cmd_t left_intake;
    cmd_t right_intake;
    cmd_t top_roller;
  } ctl_t;

  // operands of the pid sum after the state update
  typedef struct packed {
    ctl_t                      ctl;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } tick_t;

  // one result item
  typedef struct packed {
    action_t                   lift_action;
    logic signed [DRIVE_W-1:0] lift_drive_mv;
    cmd_t                      left_intake;
    cmd_t                      right_intake;
    cmd_t                      top_roller;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/lpic_regs.sv -----
// lift pid and intake control: configuration register file
// depends on lpic_pkg
`default_nettype none

module lpic_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [lpic_pkg::CFG_ADDR_W-1:0]   wr_addr,
  input  wire logic [lpic_pkg::GAIN_W-1:0]       wr_data,
  output lpic_pkg::cfg_t                         cfg
);

  lpic_pkg::reg_idx_t idx;

  assign idx = lpic_pkg::reg_idx_t'(wr_addr);

  // register writes, reset to the power-up tuning
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain        <= 24'sd11200;
      cfg.i_gain        <= 24'sd0;
      cfg.d_gain        <= 24'sd0;
      cfg.dead_band     <= 16'd16;
      cfg.integral_zone <= 16'd160;
      cfg.top_target    <= 20'sd8000;
      cfg.bottom_target <= 20'sd80;
      cfg.coast_margin  <= 16'd160;
    end else if (wr_en) begin
      unique case (idx)
        lpic_pkg::REG_P_GAIN:        cfg.p_gain        <= $signed(wr_data);
        lpic_pkg::REG_I_GAIN:        cfg.i_gain        <= $signed(wr_data);
        lpic_pkg::REG_D_GAIN:        cfg.d_gain        <= $signed(wr_data);
        lpic_pkg::REG_DEAD_BAND:     cfg.dead_band     <= wr_data[15:0];
        lpic_pkg::REG_INTEGRAL_ZONE: cfg.integral_zone <= wr_data[15:0];
        lpic_pkg::REG_TOP_TARGET:    cfg.top_target    <= $signed(wr_data[19:0]);
        lpic_pkg::REG_BOTTOM_TARGET: cfg.bottom_target <= $signed(wr_data[19:0]);
        lpic_pkg::REG_COAST_MARGIN:  cfg.coast_margin  <= wr_data[15:0];
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpic_tick.sv -----
// lift pid and intake control: input register, lift and pid state update,
// integral zone logic and intake commands; depends on lpic_pkg
`default_nettype none

module lpic_tick (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lpic_pkg::cfg_t                    cfg,
  input  wire logic                              in_load,
  input  wire logic [lpic_pkg::IN_DATA_W-1:0]    in_data,
  input  wire logic                              upd,
  input  wire logic                              tick_load,
  output lpic_pkg::tick_t                        tick
);

  // input register
  logic signed [lpic_pkg::ANGLE_W-1:0] angle;
  logic l1, l2, r1, r2;

  // controller state
  logic                                lift_raised;
  logic                                pid_enabled;
  logic signed [lpic_pkg::ANGLE_W-1:0] target_angle;
  logic signed [lpic_pkg::ERR_W-1:0]   previous_error;
  logic signed [lpic_pkg::INTEG_W-1:0] error_integral;

  logic                                lift_raised_next;
  logic                                pid_enabled_next;
  logic signed [lpic_pkg::ANGLE_W-1:0] target_angle_next;

  logic signed [lpic_pkg::ERR_W-1:0]   err;
  logic [lpic_pkg::ERR_W-1:0]          mag;
  logic signed [lpic_pkg::INTEG_W:0]   integ_sum;
  logic signed [lpic_pkg::INTEG_W-1:0] integ_sat;
  logic signed [lpic_pkg::INTEG_W-1:0] integ_new;
  logic signed [lpic_pkg::DERIV_W-1:0] deriv;
  logic signed [lpic_pkg::DERIV_W-1:0] coast_limit;
  logic signed [lpic_pkg::DERIV_W-1:0] angle_ext;
  logic                                in_zone;
  logic                                sign_flip;
  logic                                step;
  logic                                coast;
  lpic_pkg::cmd_t                      li, ri, tr;

  // input register
  always_ff @(posedge clk) begin
    if (in_load) begin
      angle <= $signed(in_data[19:0]);
      l1    <= in_data[20];
      l2    <= in_data[21];
      r1    <= in_data[22];
      r2    <= in_data[23];
    end
  end

  // lift target selection, raise wins over lower
  always_comb begin
    lift_raised_next  = lift_raised;
    pid_enabled_next  = pid_enabled;
    target_angle_next = target_angle;
    if (l1) begin
      lift_raised_next  = 1'b1;
      pid_enabled_next  = 1'b1;
      target_angle_next = cfg.top_target;
    end else if (l2) begin
      lift_raised_next  = 1'b0;
      target_angle_next = cfg.bottom_target;
    end
  end

  // error, magnitude and step decision
  always_comb begin
    err  = {target_angle_next[19], target_angle_next} - {angle[19], angle};
    mag  = err[20] ? 21'(-err) : 21'(err);
    step = pid_enabled_next && (mag > {5'd0, cfg.dead_band});
  end

  // integral with zone, saturation and clear on sign change
  always_comb begin
    integ_sum = {error_integral[31], error_integral} + {{12{err[20]}}, err};
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      integ_sat = integ_sum[31:0];
    end
    in_zone   = mag < {5'd0, cfg.integral_zone};
    sign_flip = (err[20] && !previous_error[20] && (previous_error != '0)) ||
                (!err[20] && (err != '0) && previous_error[20]);
    integ_new = (in_zone && !sign_flip) ? integ_sat : '0;
    deriv     = {err[20], err} - {previous_error[20], previous_error};
  end

  // coast when lowered and below the bottom target plus margin
  always_comb begin
    angle_ext   = {{2{angle[19]}}, angle};
    coast_limit = {{2{cfg.bottom_target[19]}}, cfg.bottom_target} +
                  {6'd0, cfg.coast_margin};
    coast       = !lift_raised_next && (angle_ext < coast_limit);
  end

  // intake commands from the updated lift state
  always_comb begin
    if (!lift_raised_next) begin
      if (r1) begin
        li = lpic_pkg::CMD_FWD; ri = lpic_pkg::CMD_FWD; tr = lpic_pkg::CMD_FWD;
      end else if (r2) begin
        li = lpic_pkg::CMD_REV; ri = lpic_pkg::CMD_REV; tr = lpic_pkg::CMD_REV;
      end else begin
        li = lpic_pkg::CMD_BRAKE; ri = lpic_pkg::CMD_BRAKE; tr = lpic_pkg::CMD_BRAKE;
      end
    end else begin
      if (r1) begin
        li = lpic_pkg::CMD_FWD; ri = lpic_pkg::CMD_FWD; tr = lpic_pkg::CMD_KEEP;
      end else if (r2) begin
        li = lpic_pkg::CMD_KEEP; ri = lpic_pkg::CMD_KEEP; tr = lpic_pkg::CMD_REV;
      end else begin
        li = lpic_pkg::CMD_BRAKE; ri = lpic_pkg::CMD_BRAKE; tr = lpic_pkg::CMD_BRAKE;
      end
    end
  end

  // controller state update, once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      lift_raised    <= 1'b0;
      pid_enabled    <= 1'b0;
      target_angle   <= '0;
      previous_error <= '0;
      error_integral <= '0;
    end else if (upd) begin
      lift_raised  <= lift_raised_next;
      pid_enabled  <= pid_enabled_next;
      target_angle <= target_angle_next;
      if (step) begin
        previous_error <= err;
        error_integral <= integ_new;
      end
    end
  end

  // operand register toward the multiply stage
  always_ff @(posedge clk) begin
    if (tick_load) begin
      tick.ctl.step         <= step;
      tick.ctl.coast        <= coast;
      tick.ctl.left_intake  <= li;
      tick.ctl.right_intake <= ri;
      tick.ctl.top_roller   <= tr;
      tick.err              <= err;
      tick.integ            <= integ_new;
      tick.deriv            <= deriv;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpic_mac.sv -----
// lift pid and intake control: gain products, pid sum, scaling,
// saturation and the result register; depends on lpic_pkg
`default_nettype none

module lpic_mac (
  input  wire logic             clk,
  input  wire lpic_pkg::cfg_t   cfg,
  input  wire lpic_pkg::tick_t  tick,
  input  wire logic             prod_load,
  input  wire logic             res_load,
  output lpic_pkg::result_t     res
);

  logic signed [lpic_pkg::P_PROD_W-1:0] p_prod;
  logic signed [lpic_pkg::I_PROD_W-1:0] i_prod;
  logic signed [lpic_pkg::D_PROD_W-1:0] d_prod;
  lpic_pkg::ctl_t                       ctl;

  logic signed [lpic_pkg::SUM_W-1:0]    sum;
  logic signed [lpic_pkg::SUM_W-lpic_pkg::GAIN_FRAC_BITS-1:0] pw;
  logic signed [lpic_pkg::DRIVE_W-1:0]  pw_sat;
  lpic_pkg::action_t                    action;

  // one product per gain, registered
  always_ff @(posedge clk) begin
    if (prod_load) begin
      p_prod <= $signed(cfg.p_gain) * $signed(tick.err);
      i_prod <= $signed(cfg.i_gain) * $signed(tick.integ);
      d_prod <= $signed(cfg.d_gain) * $signed(tick.deriv);
      ctl    <= tick.ctl;
    end
  end

  // sum, floor scaling by the gain fraction and saturation
  always_comb begin
    sum = {{13{p_prod[44]}}, p_prod} + {{2{i_prod[55]}}, i_prod} +
          {{12{d_prod[45]}}, d_prod};
    pw  = sum[lpic_pkg::SUM_W-1:lpic_pkg::GAIN_FRAC_BITS];
    if (pw > 50'(lpic_pkg::DRIVE_LIMIT_MV)) begin
      pw_sat = 15'(lpic_pkg::DRIVE_LIMIT_MV);
    end else if (pw < -50'(lpic_pkg::DRIVE_LIMIT_MV)) begin
      pw_sat = -15'(lpic_pkg::DRIVE_LIMIT_MV);
    end else begin
      pw_sat = pw[lpic_pkg::DRIVE_W-1:0];
    end
  end

  // lift action selection
  always_comb begin
    if (!ctl.step) begin
      action = lpic_pkg::ACT_NONE;
    end else if (ctl.coast) begin
      action = lpic_pkg::ACT_COAST;
    end else begin
      action = lpic_pkg::ACT_DRIVE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.lift_action   <= action;
      res.lift_drive_mv <= (action == lpic_pkg::ACT_DRIVE) ? pw_sat : '0;
      res.left_intake   <= ctl.left_intake;
      res.right_intake  <= ctl.right_intake;
      res.top_roller    <= ctl.top_roller;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lift_pid_and_intake_control.sv -----
// lift pid and intake control top level: stream ports, pipeline valid chain
// depends on lpic_pkg, lpic_regs, lpic_tick, lpic_mac
// a result reaches m_tvalid through the input register, then the state update,
// gain multiply, sum and saturate
// throughput: one tick per cycle unless m_tready stalls the output; the state loop
// is the error subtract, integral add and saturate; reset: rst clears the lift and
// pid state, empties the pipeline and returns the registers to their default tuning
`default_nettype none

module lift_pid_and_intake_control (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tick in: [19:0] lift_angle, [20] button_l1, [21] button_l2,
  // [22] button_r1, [23] button_r2
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lpic_pkg::IN_DATA_W-1:0]    s_tdata,
  // result out: [1:0] lift_action, [16:2] lift_drive_mv, [18:17] left_intake,
  // [20:19] right_intake, [22:21] top_roller, [23] zero
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [lpic_pkg::OUT_DATA_W-1:0]        m_tdata,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpic_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [lpic_pkg::GAIN_W-1:0]       cfg_data
);

  lpic_pkg::cfg_t    cfg;
  lpic_pkg::tick_t   tick;
  lpic_pkg::result_t res;

  logic v_in, v_tick, v_prod;
  logic en_in, en_tick, en_prod, en_res;

  assign cfg_ready = 1'b1;

  // stage load enables, a stage loads when empty or moving on
  always_comb begin
    en_res  = !m_tvalid || m_tready;
    en_prod = !v_prod || en_res;
    en_tick = !v_tick || en_prod;
    en_in   = !v_in || en_tick;
  end

  assign s_tready = en_in;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_tick   <= 1'b0;
      v_prod   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_in)   v_in     <= s_tvalid;
      if (en_tick) v_tick   <= v_in;
      if (en_prod) v_prod   <= v_tick;
      if (en_res)  m_tvalid <= v_prod;
    end
  end

  lpic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  lpic_tick u_tick (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_load   (en_in),
    .in_data   (s_tdata),
    .upd       (en_tick && v_in),
    .tick_load (en_tick),
    .tick      (tick)
  );

  lpic_mac u_mac (
    .clk       (clk),
    .cfg       (cfg),
    .tick      (tick),
    .prod_load (en_prod),
    .res_load  (en_res),
    .res       (res)
  );

  // result packing
  assign m_tdata = {1'b0, res.top_roller, res.right_intake, res.left_intake,
                    res.lift_drive_mv, res.lift_action};

endmodule

`default_nettype wire
